@@ design/ikh_pkg.sv @@
// Shared types, codes and constants for the IR key hold, ramp and learn block.
package ikh_pkg;

  localparam int unsigned NumFunctions = 16;
  localparam int unsigned FuncW        = $clog2(NumFunctions);
  localparam int unsigned MapW         = FuncW + 1;
  localparam int unsigned CodeW        = 32;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned WalkCntW     = $clog2(NumFunctions + 1);
  localparam int unsigned GapW         = 16;
  localparam int unsigned RampW        = 8;
  localparam int unsigned TimeoutW     = 20;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 20;
  localparam int unsigned RemBitsPerStep = 2;
  localparam int unsigned RemSteps     = CountW / RemBitsPerStep;

  localparam logic [MapW-1:0] FuncNone = MapW'(NumFunctions);

  localparam logic [GapW-1:0]     RepeatGapReset    = 16'd250;
  localparam logic [GapW-1:0]     RawRepeatReset    = 16'd150;
  localparam logic [GapW-1:0]     HoldDelayReset    = 16'd350;
  localparam logic [RampW-1:0]    RampDivReset      = 8'd2;
  localparam logic [TimeoutW-1:0] LearnTimeoutReset = 20'd30000;
  localparam logic [MaskW-1:0]    RepMaskReset      = 16'd0;

  typedef enum logic [1:0] {
    CmdFrame  = 2'd0,
    CmdArm    = 2'd1,
    CmdForget = 2'd2,
    CmdLoad   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindNec    = 2'd0,
    KindRaw    = 2'd1,
    KindRepeat = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegRepeatGap    = 3'd0,
    RegRawRepeat    = 3'd1,
    RegHoldDelay    = 3'd2,
    RegRampDiv      = 3'd3,
    RegLearnTimeout = 3'd4,
    RegRepMask      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [1:0]       frame_kind;
    logic [CodeW-1:0] code_word;
    logic [FuncW-1:0] function_index;
    logic [TimeW-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic             act_valid;
    logic [FuncW-1:0] act_function;
    logic [MapW-1:0]  mapped_function;
    logic             learned;
    logic             displaced_valid;
    logic [FuncW-1:0] displaced_function;
    logic             learning_active;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
  } rem_ctl_t;

endpackage

@@ design/ikh_rem.sv @@
// Iterative remainder unit: repeat count modulo ramp divisor, two bits per cycle while step is high.
module ikh_rem (
  input  logic                          clk_i,
  input  ikh_pkg::rem_ctl_t             ctl_i,
  input  logic [ikh_pkg::CountW-1:0]    dividend_i,
  input  logic [ikh_pkg::RampW-1:0]     divisor_i,
  output logic [ikh_pkg::RampW-1:0]     rem_o
);

  logic [ikh_pkg::RampW-1:0]  rem_q, rem_d;
  logic [ikh_pkg::CountW-1:0] dvd_q, dvd_d;
  logic [ikh_pkg::RampW:0]    part;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    part  = '0;
    for (int j = 0; j < ikh_pkg::RemBitsPerStep; j++) begin
      part  = {rem_d, dvd_d[ikh_pkg::CountW-1]};
      dvd_d = {dvd_d[ikh_pkg::CountW-2:0], 1'b0};
      if (part >= {1'b0, divisor_i}) begin
        part = part - {1'b0, divisor_i};
      end
      rem_d = part[ikh_pkg::RampW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (ctl_i.step) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign rem_o = rem_q;

endmodule

@@ design/ir_key_hold_ramp_and_learn.sv @@
// Top level of the IR key hold, ramp and learn block: key table, hold tracking, learning.
//
//  Channel  | Signals                               | Dir | Word
//  ---------+---------------------------------------+-----+-----------------------------
//  in       | in_valid_i, in_ready_o, in_data_i     | in  | command or decoded IR frame
//  out      | out_valid_o, out_ready_i, out_data_o  | out | one result word per input word
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i      | in  | register write, no wait
//
// Sequence: a frame word is accepted, walks the code RAM with one read per cycle,
// then updates; arm, forget and load go from acceptance straight to the update.
// The walk also covers the 16 two-bit steps of the repeat-count remainder.
// Reset: registers return to defaults, bound bits and hold/learn state clear;
// the code RAM keeps its contents and needs no clearing pass.
// Stalls: a result waiting in the output register blocks only the update cycle
// of the next word; input is taken again as soon as that word retires.
module ir_key_hold_ramp_and_learn (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ikh_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ikh_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ikh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ikh_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StProc = 2'd2;

  localparam int unsigned FuncW = ikh_pkg::FuncW;
  localparam int unsigned MapW  = ikh_pkg::MapW;
  localparam int unsigned CodeW = ikh_pkg::CodeW;
  localparam int unsigned TimeW = ikh_pkg::TimeW;

  // Configuration registers
  logic [ikh_pkg::GapW-1:0]     repeat_gap_q, raw_repeat_q, hold_delay_q;
  logic [ikh_pkg::RampW-1:0]    ramp_div_q;
  logic [ikh_pkg::TimeoutW-1:0] learn_timeout_q;
  logic [ikh_pkg::MaskW-1:0]    rep_mask_q;

  // Sequencer and per-word capture
  logic [1:0]                 state_q;
  logic [ikh_pkg::WalkCntW-1:0] cnt_q;
  ikh_pkg::in_t               item_q;
  logic [MapW-1:0]            mapped_q;
  logic                       disp_valid_q;
  logic [FuncW-1:0]           disp_func_q;

  // Key table: codes in RAM, bound bits in flops
  logic [CodeW-1:0]              code_mem [ikh_pkg::NumFunctions];
  logic [CodeW-1:0]              rdata_q;
  logic [ikh_pkg::NumFunctions-1:0] bound_q, bound_d;

  // Learn and hold state
  logic                       learn_armed_q, learn_armed_d;
  logic [FuncW-1:0]           learn_target_q, learn_target_d;
  logic [TimeW-1:0]           learn_time_q, learn_time_d;
  logic                       held_valid_q, held_valid_d;
  logic [FuncW-1:0]           held_func_q, held_func_d;
  logic [CodeW-1:0]           held_code_q, held_code_d;
  logic [TimeW-1:0]           held_since_q, held_since_d;
  logic [TimeW-1:0]           held_last_q, held_last_d;
  logic [ikh_pkg::CountW-1:0] held_count_q, held_count_d;

  logic                       out_valid_q;
  ikh_pkg::out_t              out_q, res;

  logic                       in_fire, proc_done;
  logic                       is_frame, is_full, is_frame_in;
  logic                       rd_en, walk_last, cmp_en, hit, disp_hit;
  logic [FuncW-1:0]           cmp_idx;
  logic                       learn_fresh, learn_live;
  logic                       gap_ok, raw_ok, delay_ok;
  logic [TimeW-1:0]           learn_age, last_gap, hold_age;
  logic [ikh_pkg::CountW-1:0] count_inc;
  logic [ikh_pkg::RampW-1:0]  div_eff, rem;
  ikh_pkg::rem_ctl_t          rem_ctl;

  logic                       mem_we;
  logic [FuncW-1:0]           mem_waddr;
  logic                       bset, bclr;
  logic [FuncW-1:0]           bidx;
  logic                       proceed, repeat_hit, func_ok, fire;
  logic [FuncW-1:0]           func;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign proc_done   = (state_q == StProc) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Word classification
  assign is_frame_in = (in_data_i.cmd == ikh_pkg::CmdFrame) &&
                       ((in_data_i.frame_kind == ikh_pkg::KindNec) ||
                        (in_data_i.frame_kind == ikh_pkg::KindRaw) ||
                        (in_data_i.frame_kind == ikh_pkg::KindRepeat));
  assign is_frame    = (item_q.cmd == ikh_pkg::CmdFrame) &&
                       ((item_q.frame_kind == ikh_pkg::KindNec) ||
                        (item_q.frame_kind == ikh_pkg::KindRaw) ||
                        (item_q.frame_kind == ikh_pkg::KindRepeat));
  assign is_full     = (item_q.frame_kind == ikh_pkg::KindNec) ||
                       (item_q.frame_kind == ikh_pkg::KindRaw);

  // Wrapping time differences
  assign learn_age   = item_q.time_ms - learn_time_q;
  assign last_gap    = item_q.time_ms - held_last_q;
  assign hold_age    = item_q.time_ms - held_since_q;
  assign learn_fresh = learn_age < TimeW'(learn_timeout_q);
  assign learn_live  = learn_armed_q && learn_fresh;
  assign gap_ok      = last_gap <= TimeW'(repeat_gap_q);
  assign raw_ok      = last_gap <= TimeW'(raw_repeat_q);
  assign delay_ok    = !(hold_age < TimeW'(hold_delay_q));

  // Table walk: read entry cnt, compare entry cnt-1 read in the cycle before
  assign rd_en     = (state_q == StWalk) && (cnt_q < ikh_pkg::WalkCntW'(ikh_pkg::NumFunctions));
  assign walk_last = (cnt_q == ikh_pkg::WalkCntW'(ikh_pkg::NumFunctions));
  assign cmp_en    = (state_q == StWalk) && (cnt_q != '0);
  assign cmp_idx   = FuncW'(cnt_q - 1'b1);
  assign hit       = cmp_en && is_full && bound_q[cmp_idx] && (rdata_q == item_q.code_word);
  assign disp_hit  = hit && learn_live && (cmp_idx != learn_target_q);

  // Remainder of the incremented repeat count runs alongside the walk
  assign count_inc    = held_count_q + ikh_pkg::CountW'(1);
  assign div_eff      = (ramp_div_q == '0) ? ikh_pkg::RampW'(1) : ramp_div_q;
  assign rem_ctl.load = in_fire;
  assign rem_ctl.step = (state_q == StWalk) &&
                        (cnt_q < ikh_pkg::WalkCntW'(ikh_pkg::RemSteps));

  ikh_rem u_rem (
    .clk_i      (clk_i),
    .ctl_i      (rem_ctl),
    .dividend_i (count_inc),
    .divisor_i  (div_eff),
    .rem_o      (rem)
  );

  // Update cycle: result word and next state
  always_comb begin
    res            = '0;
    res.mapped_function = ikh_pkg::FuncNone;
    learn_armed_d  = learn_armed_q;
    learn_target_d = learn_target_q;
    learn_time_d   = learn_time_q;
    held_valid_d   = held_valid_q;
    held_func_d    = held_func_q;
    held_code_d    = held_code_q;
    held_since_d   = held_since_q;
    held_last_d    = held_last_q;
    held_count_d   = held_count_q;
    mem_we         = 1'b0;
    mem_waddr      = item_q.function_index;
    bset           = 1'b0;
    bclr           = 1'b0;
    bidx           = item_q.function_index;
    proceed        = 1'b0;
    repeat_hit     = 1'b0;
    func_ok        = 1'b0;
    fire           = 1'b0;
    func           = '0;

    unique case (item_q.cmd)
      ikh_pkg::CmdFrame: begin
        if (is_frame) begin
          proceed = 1'b1;
          if (is_full) begin
            res.mapped_function = mapped_q;
          end
          if (learn_armed_q) begin
            if (!learn_fresh) begin
              learn_armed_d = 1'b0;
            end else if (is_full) begin
              // bind the code to the armed function; the walk already unbound others
              mem_we        = 1'b1;
              mem_waddr     = learn_target_q;
              bset          = 1'b1;
              bidx          = learn_target_q;
              res.learned   = 1'b1;
              res.displaced_valid    = disp_valid_q;
              res.displaced_function = disp_func_q;
              learn_armed_d = 1'b0;
              held_valid_d  = 1'b0;
              proceed       = 1'b0;
            end else begin
              proceed = 1'b0;
            end
          end

          if (proceed) begin
            if (!is_full) begin
              if (held_valid_q && gap_ok) begin
                func       = held_func_q;
                func_ok    = 1'b1;
                repeat_hit = 1'b1;
              end
            end else if (mapped_q == ikh_pkg::FuncNone) begin
              held_valid_d = 1'b0;
              proceed      = 1'b0;
            end else begin
              func    = mapped_q[FuncW-1:0];
              func_ok = 1'b1;
              if (held_valid_q && (held_func_q == func) &&
                  (held_code_q == item_q.code_word) && raw_ok) begin
                repeat_hit = 1'b1;
              end else begin
                // fresh press starts a new hold
                held_valid_d = 1'b1;
                held_func_d  = func;
                held_code_d  = item_q.code_word;
                held_since_d = item_q.time_ms;
                held_count_d = '0;
              end
            end
          end

          if (proceed) begin
            held_last_d = item_q.time_ms;
            if (repeat_hit) begin
              held_count_d = count_inc;
            end
            if (func_ok) begin
              fire = !repeat_hit ||
                     (rep_mask_q[func] && delay_ok && (rem == '0));
              if (fire) begin
                res.act_valid    = 1'b1;
                res.act_function = func;
              end
            end
          end
        end
      end
      ikh_pkg::CmdArm: begin
        learn_armed_d  = 1'b1;
        learn_target_d = item_q.function_index;
        learn_time_d   = item_q.time_ms;
      end
      ikh_pkg::CmdForget: begin
        bclr = 1'b1;
        if (learn_armed_q && (learn_target_q == item_q.function_index)) begin
          learn_armed_d = 1'b0;
        end
      end
      ikh_pkg::CmdLoad: begin
        mem_we = 1'b1;
        bset   = 1'b1;
      end
      default: begin
      end
    endcase

    res.learning_active = learn_armed_d;
  end

  // Bound bits: clear displaced entries during the walk, set/clear on update
  always_comb begin
    bound_d = bound_q;
    if (disp_hit) begin
      bound_d[cmp_idx] = 1'b0;
    end
    if (proc_done) begin
      if (bclr) begin
        bound_d[bidx] = 1'b0;
      end
      if (bset) begin
        bound_d[bidx] = 1'b1;
      end
    end
  end

  // Code RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (proc_done && mem_we) begin
      code_mem[mem_waddr] <= item_q.code_word;
    end
    if (rd_en) begin
      rdata_q <= code_mem[cnt_q[FuncW-1:0]];
    end
  end

  // Per-word capture and walk results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q       <= in_data_i;
      mapped_q     <= ikh_pkg::FuncNone;
      disp_valid_q <= 1'b0;
      disp_func_q  <= '0;
    end else if (state_q == StWalk) begin
      if (hit && (mapped_q == ikh_pkg::FuncNone)) begin
        mapped_q <= {1'b0, cmp_idx};
      end
      if (disp_hit && !disp_valid_q) begin
        disp_valid_q <= 1'b1;
        disp_func_q  <= cmp_idx;
      end
    end
    if (proc_done) begin
      out_q <= res;
    end
  end

  // Sequencer, architectural state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
      bound_q         <= '0;
      learn_armed_q   <= 1'b0;
      learn_target_q  <= '0;
      learn_time_q    <= '0;
      held_valid_q    <= 1'b0;
      held_func_q     <= '0;
      held_code_q     <= '0;
      held_since_q    <= '0;
      held_last_q     <= '0;
      held_count_q    <= '0;
      repeat_gap_q    <= ikh_pkg::RepeatGapReset;
      raw_repeat_q    <= ikh_pkg::RawRepeatReset;
      hold_delay_q    <= ikh_pkg::HoldDelayReset;
      ramp_div_q      <= ikh_pkg::RampDivReset;
      learn_timeout_q <= ikh_pkg::LearnTimeoutReset;
      rep_mask_q      <= ikh_pkg::RepMaskReset;
    end else begin
      bound_q <= bound_d;

      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            cnt_q   <= '0;
            // frames of a known kind walk the table; other words go straight to update
            state_q <= is_frame_in ? StWalk : StProc;
          end
        end
        StWalk: begin
          cnt_q <= cnt_q + 1'b1;
          if (walk_last) begin
            state_q <= StProc;
          end
        end
        StProc: begin
          if (proc_done) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      if (proc_done) begin
        out_valid_q    <= 1'b1;
        learn_armed_q  <= learn_armed_d;
        learn_target_q <= learn_target_d;
        learn_time_q   <= learn_time_d;
        held_valid_q   <= held_valid_d;
        held_func_q    <= held_func_d;
        held_code_q    <= held_code_d;
        held_since_q   <= held_since_d;
        held_last_q    <= held_last_d;
        held_count_q   <= held_count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ikh_pkg::RegRepeatGap:    repeat_gap_q    <= cfg_wdata_i[ikh_pkg::GapW-1:0];
          ikh_pkg::RegRawRepeat:    raw_repeat_q    <= cfg_wdata_i[ikh_pkg::GapW-1:0];
          ikh_pkg::RegHoldDelay:    hold_delay_q    <= cfg_wdata_i[ikh_pkg::GapW-1:0];
          ikh_pkg::RegRampDiv:      ramp_div_q      <= cfg_wdata_i[ikh_pkg::RampW-1:0];
          ikh_pkg::RegLearnTimeout: learn_timeout_q <= cfg_wdata_i[ikh_pkg::TimeoutW-1:0];
          ikh_pkg::RegRepMask:      rep_mask_q      <= cfg_wdata_i[ikh_pkg::MaskW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Walk counter never runs past the compare of the last entry
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (cnt_q <= ikh_pkg::WalkCntW'(ikh_pkg::NumFunctions)))
    else $error("walk counter overran the table");

  // Remainder is settled below the divisor by the time a frame is updated
  a_rem_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StProc) && is_frame) |-> (rem < div_eff))
    else $error("repeat remainder not settled");

  // A learn always disarms and is the only source of a displacement
  a_learn_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!(out_data_o.learned && out_data_o.learning_active) &&
                     !(out_data_o.displaced_valid && !out_data_o.learned)))
    else $error("learn result fields inconsistent");

  // After a learn the armed target is bound
  a_learn_binds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_done && res.learned) |=> bound_q[$past(learn_target_q)])
    else $error("learned function not bound");

endmodule

@@ verif/tb_ir_key_hold_ramp_and_learn.sv @@
// Self-checking testbench for the IR key hold, ramp and learn block.
`timescale 1ns / 1ps

module tb_ir_key_hold_ramp_and_learn;

  // Frame kind that the block must ignore; the package has no name for it.
  localparam logic [1:0]  KindUnused  = 2'd3;
  // Give up after this many cycles without a word moving on either channel.
  localparam int unsigned QuietLimit  = 5000;
  // Cycles to let pass once nothing is outstanding.
  localparam int unsigned SettleCycles = 40;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  ikh_pkg::in_t                 in_data   = '0;
  logic                         out_ready = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [ikh_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [ikh_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                         in_ready;
  logic                         out_valid;
  ikh_pkg::out_t                out_data;

  ir_key_hold_ramp_and_learn u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Words waiting to be sent, and the results they are predicted to produce.
  ikh_pkg::in_t  key_words_q[$];
  ikh_pkg::out_t outcome_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic        holding        = 1'b0;

  // Running millisecond clock for generated traffic, and the codes it presses.
  logic [31:0] clock_ms = '0;
  logic [ikh_pkg::CodeW-1:0] code_pool [8];

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the key tracker itself.
  // ---------------------------------------------------------------------------
  logic [ikh_pkg::GapW-1:0]     cfg_repeat_gap    = ikh_pkg::RepeatGapReset;
  logic [ikh_pkg::GapW-1:0]     cfg_raw_repeat    = ikh_pkg::RawRepeatReset;
  logic [ikh_pkg::GapW-1:0]     cfg_hold_delay    = ikh_pkg::HoldDelayReset;
  logic [ikh_pkg::RampW-1:0]    cfg_ramp_div      = ikh_pkg::RampDivReset;
  logic [ikh_pkg::TimeoutW-1:0] cfg_learn_timeout = ikh_pkg::LearnTimeoutReset;
  logic [ikh_pkg::MaskW-1:0]    cfg_rep_mask      = ikh_pkg::RepMaskReset;

  logic [ikh_pkg::CodeW-1:0]        key_code_tab [ikh_pkg::NumFunctions] = '{default: '0};
  logic [ikh_pkg::NumFunctions-1:0] key_bound_tab  = '0;
  logic                             learn_armed    = 1'b0;
  logic [ikh_pkg::FuncW-1:0]        learn_target   = '0;
  logic [ikh_pkg::TimeW-1:0]        learn_armed_at = '0;
  logic                             held_valid     = 1'b0;
  logic [ikh_pkg::FuncW-1:0]        held_func      = '0;
  logic [ikh_pkg::CodeW-1:0]        held_code      = '0;
  logic [ikh_pkg::TimeW-1:0]        held_since     = '0;
  logic [ikh_pkg::TimeW-1:0]        held_last_at   = '0;
  logic [ikh_pkg::CountW-1:0]       held_count     = '0;

  // Advance the key tracker by one word and return the result it must give.
  function automatic ikh_pkg::out_t resolve_key_event(ikh_pkg::in_t w);
    ikh_pkg::out_t            r;
    logic                     full;
    logic                     proceed;
    logic                     is_rep;
    logic                     fire;
    logic [ikh_pkg::MapW-1:0] func;
    logic [ikh_pkg::MapW-1:0] hit;
    logic [31:0]              elapsed;
    logic [31:0]              div;
    r = '0;
    r.mapped_function = ikh_pkg::FuncNone;
    hit = ikh_pkg::FuncNone;
    if (w.cmd == ikh_pkg::CmdFrame && w.frame_kind != KindUnused) begin
      full    = (w.frame_kind != ikh_pkg::KindRepeat);
      func    = ikh_pkg::FuncNone;
      is_rep  = 1'b0;
      proceed = 1'b1;
      // Lowest bound entry with an exact code match wins; scan downward.
      if (full) begin
        for (int i = ikh_pkg::NumFunctions - 1; i >= 0; i--) begin
          if (key_bound_tab[i] && key_code_tab[i] == w.code_word) hit = ikh_pkg::MapW'(i);
        end
        r.mapped_function = hit;
      end
      if (learn_armed) begin
        elapsed = w.time_ms - learn_armed_at;
        if (elapsed >= 32'(cfg_learn_timeout)) begin
          learn_armed = 1'b0;
        end else if (full) begin
          // Take the code from every other holder, report the lowest one.
          for (int i = 0; i < ikh_pkg::NumFunctions; i++) begin
            if (i != learn_target && key_bound_tab[i] && key_code_tab[i] == w.code_word) begin
              key_bound_tab[i] = 1'b0;
              if (!r.displaced_valid) begin
                r.displaced_valid    = 1'b1;
                r.displaced_function = ikh_pkg::FuncW'(i);
              end
            end
          end
          key_code_tab[learn_target]  = w.code_word;
          key_bound_tab[learn_target] = 1'b1;
          r.learned   = 1'b1;
          learn_armed = 1'b0;
          held_valid  = 1'b0;
          proceed     = 1'b0;
        end else begin
          proceed = 1'b0;
        end
      end
      if (proceed) begin
        elapsed = w.time_ms - held_last_at;
        if (!full) begin
          if (held_valid && elapsed <= 32'(cfg_repeat_gap)) begin
            func   = {1'b0, held_func};
            is_rep = 1'b1;
          end
        end else begin
          func = hit;
          if (func >= ikh_pkg::NumFunctions) begin
            held_valid = 1'b0;
            proceed    = 1'b0;
          end else if (held_valid && held_func == func[ikh_pkg::FuncW-1:0] &&
                       held_code == w.code_word && elapsed <= 32'(cfg_raw_repeat)) begin
            is_rep = 1'b1;
          end else begin
            held_valid = 1'b1;
            held_func  = func[ikh_pkg::FuncW-1:0];
            held_code  = w.code_word;
            held_since = w.time_ms;
            held_count = '0;
          end
        end
      end
      if (proceed) begin
        // Orphan or stale repeats still move the last-seen time.
        held_last_at = w.time_ms;
        if (is_rep) held_count = held_count + ikh_pkg::CountW'(1);
        if (func < ikh_pkg::NumFunctions) begin
          fire = 1'b1;
          if (is_rep) begin
            div     = (cfg_ramp_div == '0) ? 32'd1 : 32'(cfg_ramp_div);
            elapsed = w.time_ms - held_since;
            if (!cfg_rep_mask[func[ikh_pkg::FuncW-1:0]] || elapsed < 32'(cfg_hold_delay) ||
                held_count % div != 0) begin
              fire = 1'b0;
            end
          end
          if (fire) begin
            r.act_valid    = 1'b1;
            r.act_function = func[ikh_pkg::FuncW-1:0];
          end
        end
      end
    end else if (w.cmd == ikh_pkg::CmdArm) begin
      learn_armed    = 1'b1;
      learn_target   = w.function_index;
      learn_armed_at = w.time_ms;
    end else if (w.cmd == ikh_pkg::CmdForget) begin
      key_bound_tab[w.function_index] = 1'b0;
      if (learn_armed && learn_target == w.function_index) learn_armed = 1'b0;
    end else if (w.cmd == ikh_pkg::CmdLoad) begin
      key_code_tab[w.function_index]  = w.code_word;
      key_bound_tab[w.function_index] = 1'b1;
    end
    r.learning_active = learn_armed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: hold valid and the word until taken, then maybe idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict on acceptance so the tracker sees words in the block's order.
      if (in_valid && in_ready) begin
        outcome_q.push_back(resolve_key_event(in_data));
        key_words_q.delete(0);
        holding = 1'b0;
      end else begin
        holding = in_valid;
      end
      // Only one assignment to valid per edge, so back-to-back words stay high.
      if (!holding) begin
        if (key_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= key_words_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: check each taken result against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  task automatic check_outcome(ikh_pkg::out_t want, ikh_pkg::out_t got);
    flag_field("act_valid",          32'(want.act_valid),          32'(got.act_valid));
    flag_field("act_function",       32'(want.act_function),       32'(got.act_function));
    flag_field("mapped_function",    32'(want.mapped_function),    32'(got.mapped_function));
    flag_field("learned",            32'(want.learned),            32'(got.learned));
    flag_field("displaced_valid",    32'(want.displaced_valid),    32'(got.displaced_valid));
    flag_field("displaced_function", 32'(want.displaced_function),
               32'(got.displaced_function));
    flag_field("learning_active",    32'(want.learning_active),    32'(got.learning_active));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word expected none got %h", $time, out_data);
        end else begin
          check_outcome(outcome_q.pop_front(), out_data);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and stimulus.
  // ---------------------------------------------------------------------------
  task automatic write_reg(ikh_pkg::cfg_reg_e idx, logic [ikh_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ikh_pkg::RegRepeatGap:    cfg_repeat_gap    = val[ikh_pkg::GapW-1:0];
      ikh_pkg::RegRawRepeat:    cfg_raw_repeat    = val[ikh_pkg::GapW-1:0];
      ikh_pkg::RegHoldDelay:    cfg_hold_delay    = val[ikh_pkg::GapW-1:0];
      ikh_pkg::RegRampDiv:      cfg_ramp_div      = val[ikh_pkg::RampW-1:0];
      ikh_pkg::RegLearnTimeout: cfg_learn_timeout = val[ikh_pkg::TimeoutW-1:0];
      ikh_pkg::RegRepMask:      cfg_rep_mask      = val[ikh_pkg::MaskW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [ikh_pkg::GapW-1:0] gap, logic [ikh_pkg::GapW-1:0] raw,
                                logic [ikh_pkg::GapW-1:0] hold,
                                logic [ikh_pkg::RampW-1:0] ramp,
                                logic [ikh_pkg::TimeoutW-1:0] timeout,
                                logic [ikh_pkg::MaskW-1:0] mask);
    write_reg(ikh_pkg::RegRepeatGap,    ikh_pkg::CfgDataW'(gap));
    write_reg(ikh_pkg::RegRawRepeat,    ikh_pkg::CfgDataW'(raw));
    write_reg(ikh_pkg::RegHoldDelay,    ikh_pkg::CfgDataW'(hold));
    write_reg(ikh_pkg::RegRampDiv,      ikh_pkg::CfgDataW'(ramp));
    write_reg(ikh_pkg::RegLearnTimeout, ikh_pkg::CfgDataW'(timeout));
    write_reg(ikh_pkg::RegRepMask,      ikh_pkg::CfgDataW'(mask));
  endtask

  task automatic add_word(logic [1:0] cmd, logic [1:0] kind, logic [ikh_pkg::CodeW-1:0] code,
                          logic [ikh_pkg::FuncW-1:0] fn, logic [ikh_pkg::TimeW-1:0] t);
    ikh_pkg::in_t w;
    w.cmd            = cmd;
    w.frame_kind     = kind;
    w.code_word      = code;
    w.function_index = fn;
    w.time_ms        = t;
    key_words_q.push_back(w);
  endtask

  // Wait until every word is sent and checked, then let the block settle.
  task automatic drain();
    while (key_words_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Gap between presses: mostly short, sometimes long, rarely a full wrap jump.
  function automatic logic [31:0] step_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 70) return $urandom_range(1, 160);
    if (r < 90) return $urandom_range(160, 800);
    if (r < 97) return $urandom_range(800, 70000);
    return $urandom;
  endfunction

  function automatic logic [ikh_pkg::CodeW-1:0] pick_code();
    if ($urandom_range(9) == 0) return $urandom;
    return code_pool[$urandom_range(7)];
  endfunction

  // Random 2-bit and function-index fields.
  function automatic logic [1:0] rand2();
    return 2'($urandom);
  endfunction

  function automatic logic [ikh_pkg::FuncW-1:0] rand_fn();
    return ikh_pkg::FuncW'($urandom);
  endfunction

  // Mostly well-formed episodes (press and hold, learn, load, forget), some noise.
  task automatic add_random_traffic(int unsigned n_words);
    int unsigned               added;
    int unsigned               pick;
    int unsigned               reps;
    logic [ikh_pkg::CodeW-1:0] code;
    logic [1:0]                kind;
    added = 0;
    while (added < n_words) begin
      pick = $urandom_range(99);
      clock_ms = clock_ms + step_ms();
      if (pick < 52) begin
        code = pick_code();
        kind = $urandom_range(1) ? ikh_pkg::KindNec : ikh_pkg::KindRaw;
        add_word(ikh_pkg::CmdFrame, kind, code, rand_fn(), clock_ms);
        added++;
        reps = $urandom_range(12);
        repeat (reps) begin
          clock_ms = clock_ms + (($urandom_range(9) == 0) ? step_ms() : $urandom_range(95, 125));
          // Raw remotes hold by resending the frame; NEC sends repeat frames.
          if (kind == ikh_pkg::KindRaw && $urandom_range(3) != 0) begin
            add_word(ikh_pkg::CmdFrame, ikh_pkg::KindRaw, code, rand_fn(), clock_ms);
          end else begin
            add_word(ikh_pkg::CmdFrame, ikh_pkg::KindRepeat, $urandom, rand_fn(), clock_ms);
          end
          added++;
        end
      end else if (pick < 64) begin
        add_word(ikh_pkg::CmdArm, rand2(), $urandom, rand_fn(), clock_ms);
        added++;
        if ($urandom_range(3) == 0) begin
          clock_ms = clock_ms + $urandom_range(0, 120);
          add_word(ikh_pkg::CmdFrame, ikh_pkg::KindRepeat, $urandom, rand_fn(), clock_ms);
          added++;
        end
        clock_ms = clock_ms + (($urandom_range(4) == 0) ? step_ms() : $urandom_range(0, 300));
        kind = $urandom_range(1) ? ikh_pkg::KindNec : ikh_pkg::KindRaw;
        add_word(ikh_pkg::CmdFrame, kind, pick_code(), rand_fn(), clock_ms);
        added++;
      end else if (pick < 78) begin
        add_word(ikh_pkg::CmdLoad, rand2(), pick_code(), rand_fn(), clock_ms);
        added++;
      end else if (pick < 85) begin
        add_word(ikh_pkg::CmdForget, rand2(), $urandom, rand_fn(), clock_ms);
        added++;
      end else begin
        add_word(rand2(), rand2(), $urandom, rand_fn(),
                 ($urandom_range(3) == 0) ? $urandom : clock_ms);
        added++;
      end
    end
  endtask

  initial begin
    foreach (code_pool[i]) code_pool[i] = $urandom;
    code_pool[6] = '0;
    code_pool[7] = '1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: sender idles 21%, receiver 55%.
    send_idle_pct = 21;
    recv_idle_pct = 55;
    apply_settings(16'd250, 16'd150, 16'd350, 8'd2, 20'd30000, 16'hFFFF);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindNec,    32'h0000_0000, 4'h0, 32'd0);  // unbound
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'd10); // orphan
    add_word(ikh_pkg::CmdFrame,  KindUnused,          32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
    add_word(ikh_pkg::CmdLoad,   ikh_pkg::KindNec,    32'hFFFF_FFFF, 4'h0, 32'd20);
    add_word(ikh_pkg::CmdLoad,   ikh_pkg::KindNec,    32'h0000_0000, 4'hF, 32'd30);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindNec,    32'hFFFF_FFFF, 4'h0, 32'd100); // press
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'd200); // in delay
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'd450); // fires
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'd560); // skips
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'd900); // stale
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRaw,    32'h0000_0000, 4'h0, 32'd950);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRaw,    32'h0000_0000, 4'h0, 32'd1000); // hold
    add_word(ikh_pkg::CmdArm,    ikh_pkg::KindNec,    32'h0000_0000, 4'h7, 32'd2000);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'd2010); // armed
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindNec,    32'hFFFF_FFFF, 4'h0, 32'd2020); // learn
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindNec,    32'hFFFF_FFFF, 4'h0, 32'd2030);
    add_word(ikh_pkg::CmdForget, ikh_pkg::KindNec,    32'h0000_0000, 4'h7, 32'd2040);
    add_word(ikh_pkg::CmdArm,    ikh_pkg::KindNec,    32'h0000_0000, 4'h3, 32'd3000);
    add_word(ikh_pkg::CmdForget, ikh_pkg::KindNec,    32'h0000_0000, 4'h3, 32'd3001);
    add_word(ikh_pkg::CmdArm,    ikh_pkg::KindNec,    32'h0000_0000, 4'h5, 32'd4000);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindNec,    32'h1234_5678, 4'h0, 32'd34000); // expired
    add_word(ikh_pkg::CmdArm,    ikh_pkg::KindNec,    32'h0000_0000, 4'h2, 32'hFFFF_FF00);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindNec,    32'hA5A5_A5A5, 4'h0, 32'h0000_0010);
    add_word(ikh_pkg::CmdLoad,   ikh_pkg::KindNec,    32'hA5A5_A5A5, 4'h9, 32'h0000_0020);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRaw,    32'hA5A5_A5A5, 4'h0, 32'h0000_0030);
    add_word(ikh_pkg::CmdFrame,  ikh_pkg::KindRepeat, 32'h0000_0000, 4'h0, 32'hFFFF_0000);
    drain();

    // Random part, one register setting per block of traffic.
    clock_ms = 32'h0010_0000;
    apply_settings(16'd0, 16'd0, 16'd0, 8'd1, 20'd0, 16'hFFFF);
    add_random_traffic(300);
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 20'hFFFFF, 16'h0000);
    add_random_traffic(300);
    drain();

    // Swap the idling sides.
    send_idle_pct = 55;
    recv_idle_pct = 21;
    apply_settings(16'd300, 16'd200, 16'd400, 8'd3, 20'd2000, ikh_pkg::MaskW'($urandom));
    add_random_traffic(300);
    drain();
    // Divisor of zero acts as one.
    apply_settings(16'd250, 16'd150, 16'd350, 8'd0, 20'd30000, ikh_pkg::MaskW'($urandom));
    add_random_traffic(300);
    drain();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(ikh_pkg::GapW'($urandom_range(50, 600)),
                   ikh_pkg::GapW'($urandom_range(0, 300)),
                   ikh_pkg::GapW'($urandom_range(0, 1000)),
                   ikh_pkg::RampW'($urandom_range(1, 6)),
                   ikh_pkg::TimeoutW'($urandom_range(100, 5000)),
                   ikh_pkg::MaskW'($urandom));
    add_random_traffic(300);
    drain();
    apply_settings(ikh_pkg::GapW'($urandom_range(50, 600)),
                   ikh_pkg::GapW'($urandom_range(0, 300)),
                   ikh_pkg::GapW'($urandom_range(0, 1000)),
                   ikh_pkg::RampW'($urandom_range(1, 6)),
                   ikh_pkg::TimeoutW'($urandom_range(100, 5000)),
                   ikh_pkg::MaskW'($urandom));
    add_random_traffic(300);
    drain();

    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ikh_pkg.sv
design/ikh_rem.sv
design/ir_key_hold_ramp_and_learn.sv
verif/tb_ir_key_hold_ramp_and_learn.sv
